// ===== sv/cpt_pkg.sv =====
package cpt_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned STEP_BITS = 4;

  // Largest texture extent; wider settings saturate to it.
  localparam logic [CFG_W-1:0] MAX_DIM = 13'd4096;

  typedef enum logic [2:0] {
    CFG_TEX_WIDTH       = 3'd0,
    CFG_TEX_HEIGHT      = 3'd1,
    CFG_CELL_SIZE       = 3'd2,
    CFG_BORDER_WIDTH    = 3'd3,
    CFG_CELL_COLOR_EVEN = 3'd4,
    CFG_CELL_COLOR_ODD  = 3'd5,
    CFG_GRID_COLOR      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } texel_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               on_border;
    logic               out_of_range;
  } texel_out_t;

  // One axis in flight through the divider: position, partial remainder and
  // the quotient bit produced last. After the final stage that bit is the low
  // bit of the cell index, which is all the parity needs.
  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [COORD_W-1:0] rem;
    logic               par;
  } div_lane_t;

  typedef struct packed {
    div_lane_t c;
    div_lane_t r;
  } div_pair_t;

  // Restoring division, STEP_BITS quotient bits starting at bit msb.
  // The remainder never exceeds the position, so 12 bits hold it.
  function automatic div_lane_t div_step(div_lane_t lane, logic [CFG_W-1:0] cell_len,
                                         int unsigned msb);
    div_lane_t          res;
    logic [CFG_W-1:0]   t;
    logic [COORD_W-1:0] sh;
    res = lane;
    for (int unsigned k = 0; k < STEP_BITS; k++) begin
      sh      = lane.pos >> (msb - k);
      t       = {res.rem, sh[0]};
      res.par = (t >= cell_len);
      if (res.par) begin
        t = t - cell_len;
      end
      res.rem = t[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/cpt_div_stage.sv =====
module cpt_div_stage import cpt_pkg::*; #(
  parameter int unsigned MSB = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] cell_i,
  input  logic             valid_i,
  output logic             stall_o,
  input  div_pair_t        data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output div_pair_t        data_o
);

  logic      valid_q;
  div_pair_t data_q, data_d;

  // Hold while a result sits here and the next stage refuses it.
  assign stall_o = valid_q && stall_i;

  always_comb begin
    data_d.c = div_step(data_i.c, cell_i, MSB);
    data_d.r = div_step(data_i.r, cell_i, MSB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/checkerboard_pattern_texel_unit.sv =====
// Checkerboard test pattern texel unit. Each transfer on the input channel
// carries one texel coordinate and yields exactly one transfer on the output
// channel with its packed RGBA color and the border and out-of-range flags.
// A new coordinate can be taken in every clock while in_stall_o is low; each
// coordinate passes through the three-stage divider (four quotient bits per
// stage, one lane per axis) that finds the cell index parity and the in-cell
// offset, followed by the output register. Stalls on the output back up through
// the stages only as far as they are full. Write the configuration registers
// only while no texel is in flight.
module checkerboard_pattern_texel_unit import cpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  texel_in_t    in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output texel_out_t   out_data_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [CFG_W-1:0]   tex_width_q, tex_height_q, cell_size_q, border_width_q;
  logic [COLOR_W-1:0] color_even_q, color_odd_q, grid_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q    <= 13'd256;
      tex_height_q   <= 13'd256;
      cell_size_q    <= 13'd32;
      border_width_q <= '0;
      color_even_q   <= '0;
      color_odd_q    <= '0;
      grid_color_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEX_WIDTH:       tex_width_q    <= cfg_data_i[CFG_W-1:0];
        CFG_TEX_HEIGHT:      tex_height_q   <= cfg_data_i[CFG_W-1:0];
        CFG_CELL_SIZE:       cell_size_q    <= cfg_data_i[CFG_W-1:0];
        CFG_BORDER_WIDTH:    border_width_q <= cfg_data_i[CFG_W-1:0];
        CFG_CELL_COLOR_EVEN: color_even_q   <= cfg_data_i;
        CFG_CELL_COLOR_ODD:  color_odd_q    <= cfg_data_i;
        CFG_GRID_COLOR:      grid_color_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: zero cell acts as one, extents saturate.
  logic [CFG_W-1:0] cell_len, ext_w, ext_h;
  assign cell_len = (cell_size_q == '0) ? 13'd1 : cell_size_q;
  assign ext_w    = (tex_width_q  > MAX_DIM) ? MAX_DIM : tex_width_q;
  assign ext_h    = (tex_height_q > MAX_DIM) ? MAX_DIM : tex_height_q;

  // Divider pipeline.
  div_pair_t s0_data, s1_data, s2_data, s3_data;
  logic      s1_valid, s2_valid, s3_valid;
  logic      s1_stall, s2_stall, s3_stall;
  logic      out_valid_q;
  texel_out_t out_q, out_d;
  logic      out_hold;

  assign s0_data.c = '{pos: in_data_i.col, rem: '0, par: 1'b0};
  assign s0_data.r = '{pos: in_data_i.row, rem: '0, par: 1'b0};

  cpt_div_stage #(.MSB(11)) u_div_hi (
    .clk_i, .rst_ni, .cell_i(cell_len),
    .valid_i(in_valid_i), .stall_o(in_stall_o), .data_i(s0_data),
    .valid_o(s1_valid), .stall_i(s1_stall), .data_o(s1_data)
  );

  cpt_div_stage #(.MSB(7)) u_div_mid (
    .clk_i, .rst_ni, .cell_i(cell_len),
    .valid_i(s1_valid), .stall_o(s1_stall), .data_i(s1_data),
    .valid_o(s2_valid), .stall_i(s2_stall), .data_o(s2_data)
  );

  cpt_div_stage #(.MSB(3)) u_div_lo (
    .clk_i, .rst_ni, .cell_i(cell_len),
    .valid_i(s2_valid), .stall_o(s2_stall), .data_i(s2_data),
    .valid_o(s3_valid), .stall_i(s3_stall), .data_o(s3_data)
  );

  // Border and color decision.
  logic oor, bord_c, bord_r, bw_nz;
  assign bw_nz = (border_width_q != '0);
  assign oor   = ({1'b0, s3_data.c.pos} >= ext_w) || ({1'b0, s3_data.r.pos} >= ext_h);

  assign bord_c = bw_nz && ((border_width_q >= cell_len) || (border_width_q >= ext_w) ||
                  ({1'b0, s3_data.c.rem} < border_width_q) ||
                  ({1'b0, s3_data.c.pos} >= (ext_w - border_width_q)));
  assign bord_r = bw_nz && ((border_width_q >= cell_len) || (border_width_q >= ext_h) ||
                  ({1'b0, s3_data.r.rem} < border_width_q) ||
                  ({1'b0, s3_data.r.pos} >= (ext_h - border_width_q)));

  always_comb begin
    out_d.out_of_range = oor;
    out_d.on_border    = 1'b0;
    if (oor) begin
      out_d.color = color_even_q;
    end else if (bord_c || bord_r) begin
      out_d.on_border = 1'b1;
      out_d.color     = grid_color_q;
    end else if (s3_data.c.par ^ s3_data.r.par) begin
      out_d.color = color_odd_q;
    end else begin
      out_d.color = color_even_q;
    end
  end

  assign out_hold = out_valid_q && out_stall_i;
  assign s3_stall = out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold && s3_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
